FILE: sv/clipped_span_fill_with_wrap_assert.svh
// Assertion macros for the span fill block.
`ifndef CLIPPED_SPAN_FILL_WITH_WRAP_ASSERT_SVH
`define CLIPPED_SPAN_FILL_WITH_WRAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSWF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cswf_pkg.sv
package cswf_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned PIXEL_W = 24;
  localparam int unsigned DIM_W   = 9;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Logical pixel address before the store range check
  localparam int unsigned LADDR_W = 19;
  // frame_width * frame_height
  localparam int unsigned AREA_W  = 18;

  localparam logic [DIM_W-1:0]   FRAME_W_RST = 9'd256;
  localparam logic [DIM_W-1:0]   FRAME_H_RST = 9'd256;
  localparam logic [COORD_W-1:0] BOX_X_RST   = 8'd0;
  localparam logic [COORD_W-1:0] BOX_Y_RST   = 8'd0;
  localparam logic [DIM_W-1:0]   BOX_W_RST   = 9'd256;
  localparam logic [DIM_W-1:0]   BOX_H_RST   = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_ROW_FILL = 2'd0,
    CMD_COL_FILL = 2'd1,
    CMD_READ     = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_FRAME_W = 3'd0,
    REG_FRAME_H = 3'd1,
    REG_BOX_X   = 3'd2,
    REG_BOX_Y   = 3'd3,
    REG_BOX_W   = 3'd4,
    REG_BOX_H   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FILL,
    ST_CLEAR,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_w;
    logic [DIM_W-1:0]   frame_h;
    logic [COORD_W-1:0] box_x;
    logic [COORD_W-1:0] box_y;
    logic [DIM_W-1:0]   box_w;
    logic [DIM_W-1:0]   box_h;
  } cfg_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

FILE: sv/cswf_cmd_if.sv
interface cswf_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [cswf_pkg::CMD_W-1:0]    cmd;
  logic [cswf_pkg::COLOR_W-1:0]  color;
  logic [cswf_pkg::COUNT_W-1:0]  count;
  logic [cswf_pkg::COORD_W-1:0]  x;
  logic [cswf_pkg::COORD_W-1:0]  y;

  modport source (output valid, cmd, color, count, x, y, input ready);
  modport sink   (input valid, cmd, color, count, x, y, output ready);
endinterface

FILE: sv/cswf_res_if.sv
interface cswf_res_if;
  logic                          valid;
  logic                          ready;
  logic [cswf_pkg::POS_W-1:0]    end_x;
  logic [cswf_pkg::POS_W-1:0]    end_y;
  logic                          rejected;
  logic [cswf_pkg::PIXEL_W-1:0]  pixel;

  modport source (output valid, end_x, end_y, rejected, pixel, input ready);
  modport sink   (input valid, end_x, end_y, rejected, pixel, output ready);
endinterface

FILE: sv/cswf_cfg_regs.sv
module cswf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cswf_pkg::APB_AW-1:0]  paddr,
  input  logic [cswf_pkg::APB_DW-1:0]  pwdata,
  output logic [cswf_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output cswf_pkg::cfg_t               cfg_o
);

  cswf_pkg::cfg_t     cfg_q, cfg_d;
  cswf_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = cswf_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        cswf_pkg::REG_FRAME_W: cfg_d.frame_w = pwdata[8:0];
        cswf_pkg::REG_FRAME_H: cfg_d.frame_h = pwdata[8:0];
        cswf_pkg::REG_BOX_X:   cfg_d.box_x   = pwdata[7:0];
        cswf_pkg::REG_BOX_Y:   cfg_d.box_y   = pwdata[7:0];
        cswf_pkg::REG_BOX_W:   cfg_d.box_w   = pwdata[8:0];
        cswf_pkg::REG_BOX_H:   cfg_d.box_h   = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cswf_pkg::REG_FRAME_W: prdata = {23'd0, cfg_q.frame_w};
      cswf_pkg::REG_FRAME_H: prdata = {23'd0, cfg_q.frame_h};
      cswf_pkg::REG_BOX_X:   prdata = {24'd0, cfg_q.box_x};
      cswf_pkg::REG_BOX_Y:   prdata = {24'd0, cfg_q.box_y};
      cswf_pkg::REG_BOX_W:   prdata = {23'd0, cfg_q.box_w};
      cswf_pkg::REG_BOX_H:   prdata = {23'd0, cfg_q.box_h};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_w <= cswf_pkg::FRAME_W_RST;
      cfg_q.frame_h <= cswf_pkg::FRAME_H_RST;
      cfg_q.box_x   <= cswf_pkg::BOX_X_RST;
      cfg_q.box_y   <= cswf_pkg::BOX_Y_RST;
      cfg_q.box_w   <= cswf_pkg::BOX_W_RST;
      cfg_q.box_h   <= cswf_pkg::BOX_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: sv/cswf_frame_mem.sv
module cswf_frame_mem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned DataW = 24,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  cswf_pkg::mem_ctl_t   ctl_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [DataW-1:0]     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [DataW-1:0]     rdata_o
);

  logic [DataW-1:0] store_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cswf_engine.sv
module cswf_engine #(
  parameter int unsigned FB_WIDTH   = 256,
  parameter int unsigned FB_HEIGHT  = 256,
  parameter int unsigned PIXEL_BITS = 24,
  localparam int unsigned StoreSize = FB_WIDTH * FB_HEIGHT,
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cswf_pkg::cfg_t         cfg_i,
  cswf_cmd_if.sink               cmd_i,
  cswf_res_if.source             res_o,
  output cswf_pkg::mem_ctl_t     mem_ctl_o,
  output logic [AddrW-1:0]       waddr_o,
  output logic [PIXEL_BITS-1:0]  wdata_o,
  output logic [AddrW-1:0]       raddr_o,
  input  logic [PIXEL_BITS-1:0]  rdata_i
);

  localparam int unsigned LW = cswf_pkg::LADDR_W;
  localparam int unsigned AW = cswf_pkg::AREA_W;

  function automatic logic in_store(input logic [LW-1:0] a);
    return 32'(a) < StoreSize;
  endfunction

  cswf_pkg::state_e state_q, state_d;
  cswf_pkg::cmd_e   cmd_q, cmd_d;

  logic [cswf_pkg::COLOR_W-1:0] color_q, color_d;
  logic [cswf_pkg::COUNT_W-1:0] rem_q, rem_d;
  logic [cswf_pkg::POS_W-1:0]   c_q, c_d, r_q, r_d;
  logic                         rej_q, rej_d;
  logic [cswf_pkg::PIXEL_W-1:0] pix_q, pix_d;
  logic [AW-1:0]                clr_q, clr_d, area_q, area_d;
  logic [LW-1:0]                rd_laddr_q, rd_laddr_d;
  logic                         rd_hit_q, rd_hit_d;
  logic                         wr_vld_q, wr_vld_d;
  logic [LW-1:0]                wr_laddr_q, wr_laddr_d;

  logic                         out_valid_q, out_valid_d;
  logic [cswf_pkg::POS_W-1:0]   out_ex_q, out_ex_d, out_ey_q, out_ey_d;
  logic                         out_rej_q, out_rej_d;
  logic [cswf_pkg::PIXEL_W-1:0] out_pix_q, out_pix_d;

  logic [cswf_pkg::POS_W-1:0]   row_sum, c_inc, r_inc;
  logic [17:0]                  fill_prod;
  logic [LW-1:0]                fill_laddr;
  logic [16:0]                  rd_prod;
  logic                         fill_done, is_fill;
  logic [31:0]                  color_ext, rdata_ext;

  // Box row of the current pixel times the row stride, plus the column
  assign row_sum    = {1'b0, cfg_i.box_y} + r_q;
  assign fill_prod  = 18'(row_sum) * 18'(cfg_i.frame_w);
  assign fill_laddr = LW'(fill_prod) + LW'(cfg_i.box_x) + LW'(c_q);
  assign rd_prod    = 17'(r_q[7:0]) * 17'(cfg_i.frame_w);
  assign c_inc      = c_q + 9'd1;
  assign r_inc      = r_q + 9'd1;
  assign is_fill    = (cmd_q == cswf_pkg::CMD_ROW_FILL) || (cmd_q == cswf_pkg::CMD_COL_FILL);
  assign fill_done  = (rem_q == '0) ||
                      ((cmd_q == cswf_pkg::CMD_ROW_FILL) ? (r_q == cfg_i.box_h)
                                                         : (c_q == cfg_i.box_w));

  assign color_ext = {8'd0, color_q};
  assign rdata_ext = 32'(rdata_i);

  assign cmd_i.ready    = (state_q == cswf_pkg::ST_IDLE);
  assign res_o.valid    = out_valid_q;
  assign res_o.end_x    = out_ex_q;
  assign res_o.end_y    = out_ey_q;
  assign res_o.rejected = out_rej_q;
  assign res_o.pixel    = out_pix_q;

  // Write stage: one pixel per cycle, dropped beyond the store
  assign waddr_o      = AddrW'(wr_laddr_q);
  assign wdata_o      = PIXEL_BITS'(color_ext);
  assign raddr_o      = AddrW'(rd_laddr_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    color_d     = color_q;
    rem_d       = rem_q;
    c_d         = c_q;
    r_d         = r_q;
    rej_d       = rej_q;
    pix_d       = pix_q;
    clr_d       = clr_q;
    area_d      = area_q;
    rd_laddr_d  = rd_laddr_q;
    rd_hit_d    = rd_hit_q;
    wr_vld_d    = 1'b0;
    wr_laddr_d  = wr_laddr_q;
    out_valid_d = out_valid_q;
    out_ex_d    = out_ex_q;
    out_ey_d    = out_ey_q;
    out_rej_d   = out_rej_q;
    out_pix_d   = out_pix_q;
    mem_ctl_o.we = wr_vld_q && in_store(wr_laddr_q);
    mem_ctl_o.re = 1'b0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cswf_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cswf_pkg::cmd_e'(cmd_i.cmd);
          color_d = cmd_i.color;
          rem_d   = cmd_i.count;
          c_d     = {1'b0, cmd_i.x};
          r_d     = {1'b0, cmd_i.y};
          rej_d   = 1'b0;
          pix_d   = '0;
          state_d = cswf_pkg::ST_START;
        end
      end
      cswf_pkg::ST_START: begin
        case (cmd_q)
          cswf_pkg::CMD_ROW_FILL, cswf_pkg::CMD_COL_FILL: begin
            // Start outside the box: report the start point untouched
            if ((c_q >= cfg_i.box_w) || (r_q >= cfg_i.box_h)) begin
              rej_d   = 1'b1;
              state_d = cswf_pkg::ST_FINISH;
            end else begin
              state_d = cswf_pkg::ST_FILL;
            end
          end
          cswf_pkg::CMD_READ: begin
            rd_laddr_d = LW'(rd_prod) + LW'(c_q[7:0]);
            state_d    = cswf_pkg::ST_RD_ISSUE;
          end
          cswf_pkg::CMD_CLEAR: begin
            area_d  = AW'(cfg_i.frame_w) * AW'(cfg_i.frame_h);
            clr_d   = '0;
            state_d = cswf_pkg::ST_CLEAR;
          end
          default: state_d = cswf_pkg::ST_FINISH;
        endcase
      end
      cswf_pkg::ST_FILL: begin
        if (fill_done) begin
          state_d = cswf_pkg::ST_FINISH;
        end else begin
          wr_vld_d   = 1'b1;
          wr_laddr_d = fill_laddr;
          rem_d      = rem_q - 17'd1;
          if (cmd_q == cswf_pkg::CMD_ROW_FILL) begin
            if (c_inc == cfg_i.box_w) begin
              c_d = '0;
              r_d = r_inc;
            end else begin
              c_d = c_inc;
            end
          end else begin
            if (r_inc == cfg_i.box_h) begin
              r_d = '0;
              c_d = c_inc;
            end else begin
              r_d = r_inc;
            end
          end
        end
      end
      cswf_pkg::ST_CLEAR: begin
        if (clr_q == area_q) begin
          state_d = cswf_pkg::ST_FINISH;
        end else begin
          wr_vld_d   = 1'b1;
          wr_laddr_d = LW'(clr_q);
          clr_d      = clr_q + 18'd1;
        end
      end
      cswf_pkg::ST_RD_ISSUE: begin
        mem_ctl_o.re = in_store(rd_laddr_q);
        rd_hit_d     = in_store(rd_laddr_q);
        state_d      = cswf_pkg::ST_RD_WAIT;
      end
      cswf_pkg::ST_RD_WAIT: begin
        pix_d   = rd_hit_q ? rdata_ext[23:0] : '0;
        state_d = cswf_pkg::ST_FINISH;
      end
      cswf_pkg::ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_ex_d    = is_fill ? c_q : '0;
          out_ey_d    = is_fill ? r_q : '0;
          out_rej_d   = rej_q;
          out_pix_d   = pix_q;
          state_d     = cswf_pkg::ST_IDLE;
        end
      end
      default: state_d = cswf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cswf_pkg::ST_IDLE;
      wr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_vld_q    <= wr_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    color_q    <= color_d;
    rem_q      <= rem_d;
    c_q        <= c_d;
    r_q        <= r_d;
    rej_q      <= rej_d;
    pix_q      <= pix_d;
    clr_q      <= clr_d;
    area_q     <= area_d;
    rd_laddr_q <= rd_laddr_d;
    rd_hit_q   <= rd_hit_d;
    wr_laddr_q <= wr_laddr_d;
    out_ex_q   <= out_ex_d;
    out_ey_q   <= out_ey_d;
    out_rej_q  <= out_rej_d;
    out_pix_q  <= out_pix_d;
  end

endmodule

FILE: sv/clipped_span_fill_with_wrap.sv
// Channel  Port        Direction  Carries
// command  cmd_i       in         cmd, color, count, x, y
// result   res_o       out        end_x, end_y, rejected, pixel
// config   APB (p*)    in/out     frame_width, frame_height, box_x, box_y, box_w, box_h
//
// One command at a time; a new command is taken while the last result still waits.
// Fill: min(count, pixels left in the box) pixels, one frame store write per cycle.
// Clear: frame_width * frame_height pixel writes; read: issue, then wait for the data (one store read port).
// Reset clears control state only; the frame store holds garbage until written.
// A stalled result holds the engine in its finish step until the result is taken.
module clipped_span_fill_with_wrap #(
  parameter int unsigned FB_WIDTH   = 256,
  parameter int unsigned FB_HEIGHT  = 256,
  parameter int unsigned PIXEL_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cswf_cmd_if.sink                     cmd_i,
  cswf_res_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cswf_pkg::APB_AW-1:0]  paddr,
  input  logic [cswf_pkg::APB_DW-1:0]  pwdata,
  output logic [cswf_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned StoreSize = FB_WIDTH * FB_HEIGHT;
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;

  cswf_pkg::cfg_t         cfg;
  cswf_pkg::mem_ctl_t     mem_ctl;
  logic [AddrW-1:0]       waddr, raddr;
  logic [PIXEL_BITS-1:0]  wdata, rdata;

  cswf_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cswf_engine #(
    .FB_WIDTH   (FB_WIDTH),
    .FB_HEIGHT  (FB_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd_i),
    .res_o     (res_o),
    .mem_ctl_o (mem_ctl),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .raddr_o   (raddr),
    .rdata_i   (rdata)
  );

  cswf_frame_mem #(
    .Depth (StoreSize),
    .DataW (PIXEL_BITS)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

FILE: sv/cswf_checker.sv
`include "clipped_span_fill_with_wrap_assert.svh"

module cswf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [cswf_pkg::POS_W-1:0]    end_x,
  input logic [cswf_pkg::POS_W-1:0]    end_y,
  input logic                          rejected,
  input logic [cswf_pkg::PIXEL_W-1:0]  pixel
);

  // Commands taken whose results are not yet delivered
  logic [1:0] pend_q, pend_d;
  logic       cmd_acc, res_acc;

  assign cmd_acc = cmd_valid && cmd_ready;
  assign res_acc = res_valid && res_ready;

  always_comb begin
    pend_d = pend_q;
    if (cmd_acc && !res_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!cmd_acc && res_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `CSWF_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready, res_valid && $stable({end_x, end_y, rejected, pixel}), "result changed while stalled")
  `CSWF_ASSERT_NEXT(a_one_cmd, clk_i, rst_ni, cmd_acc, !cmd_ready, "command taken while another is in work")
  `CSWF_ASSERT_IMPL(a_res_has_cmd, clk_i, rst_ni, res_valid, pend_q != 2'd0, "result without a command")
  `CSWF_ASSERT_IMPL(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q <= 2'd2, "too many commands outstanding")
  `CSWF_ASSERT_IMPL(a_pixel_only_read, clk_i, rst_ni, res_valid && (rejected || (end_x != '0) || (end_y != '0)), pixel == '0, "pixel set on a fill result")

endmodule

bind clipped_span_fill_with_wrap cswf_checker u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .cmd_valid (cmd_i.valid),
  .cmd_ready (cmd_i.ready),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .end_x     (res_o.end_x),
  .end_y     (res_o.end_y),
  .rejected  (res_o.rejected),
  .pixel     (res_o.pixel)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import cswf_pkg::*;

  localparam int unsigned STORE_PIXELS = 256 * 256;
  localparam int unsigned IDLE_LIMIT   = 200000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 110;

  typedef struct packed {
    logic [POS_W-1:0]   end_x;
    logic [POS_W-1:0]   end_y;
    logic               rejected;
    logic [PIXEL_W-1:0] pixel;
  } span_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cswf_cmd_if cmd_if ();
  cswf_res_if res_if ();

  clipped_span_fill_with_wrap dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [PIXEL_W-1:0] frame_model [STORE_PIXELS];
  cfg_t               model_cfg;
  span_result_t       pending_results [$];
  span_result_t       want;
  int unsigned        fail_count;
  int unsigned        sent_count;
  int unsigned        checked_count;
  int unsigned        config_count;
  int unsigned        send_gap_pct;
  int unsigned        recv_stall_pct;
  int unsigned        hold_left;
  int unsigned        idle_cycles;
  bit                 hold_request;

  always #2 clk_i = ~clk_i;

  function automatic void plot_box(int unsigned col, int unsigned row,
                                   logic [PIXEL_W-1:0] color);
    int unsigned addr;
    addr = (32'(model_cfg.box_y) + row) * 32'(model_cfg.frame_w) +
           32'(model_cfg.box_x) + col;
    // drop pixels past the end of the store
    if (addr < STORE_PIXELS) frame_model[addr] = color;
  endfunction

  function automatic span_result_t predict_command(cmd_e op, logic [COLOR_W-1:0] color,
                                                   logic [COUNT_W-1:0] count,
                                                   logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y);
    span_result_t r;
    int unsigned  bw, bh, avail, n, pos, total, addr, i;
    r  = '0;
    bw = 32'(model_cfg.box_w);
    bh = 32'(model_cfg.box_h);
    case (op)
      CMD_ROW_FILL, CMD_COL_FILL: begin
        if (32'(x) >= bw || 32'(y) >= bh) begin
          r.rejected = 1'b1;
          r.end_x    = 9'(x);
          r.end_y    = 9'(y);
        end else if (op == CMD_ROW_FILL) begin
          avail = (bw - 32'(x)) + bw * (bh - 1 - 32'(y));
          n     = (32'(count) < avail) ? 32'(count) : avail;
          for (i = 0; i < n; i++) begin
            pos = 32'(y) * bw + 32'(x) + i;
            plot_box(pos % bw, pos / bw, color);
          end
          pos     = 32'(y) * bw + 32'(x) + n;
          r.end_x = 9'(pos % bw);
          r.end_y = 9'(pos / bw);
        end else begin
          avail = (bh - 32'(y)) + bh * (bw - 1 - 32'(x));
          n     = (32'(count) < avail) ? 32'(count) : avail;
          for (i = 0; i < n; i++) begin
            pos = 32'(x) * bh + 32'(y) + i;
            plot_box(pos / bh, pos % bh, color);
          end
          pos     = 32'(x) * bh + 32'(y) + n;
          r.end_x = 9'(pos / bh);
          r.end_y = 9'(pos % bh);
        end
      end
      CMD_READ: begin
        addr = 32'(y) * 32'(model_cfg.frame_w) + 32'(x);
        if (addr < STORE_PIXELS) r.pixel = frame_model[addr];
      end
      default: begin
        total = 32'(model_cfg.frame_w) * 32'(model_cfg.frame_h);
        if (total > STORE_PIXELS) total = STORE_PIXELS;
        for (i = 0; i < total; i++) frame_model[i] = color;
      end
    endcase
    return r;
  endfunction

  task automatic send_cmd(cmd_e op, logic [COLOR_W-1:0] color, logic [COUNT_W-1:0] count,
                          logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < send_gap_pct) @(negedge clk_i);
    end
    cmd_if.cmd   = op;
    cmd_if.color = color;
    cmd_if.count = count;
    cmd_if.x     = x;
    cmd_if.y     = y;
    cmd_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_command(op, color, count, x, y));
    sent_count++;
  endtask

  task automatic cmd_quiet();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
  endtask

  // Hold the command side until every pending result is back, then let the engine settle.
  task automatic wait_drained();
    cmd_quiet();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_FRAME_W: model_cfg.frame_w = value[DIM_W-1:0];
      REG_FRAME_H: model_cfg.frame_h = value[DIM_W-1:0];
      REG_BOX_X:   model_cfg.box_x   = value[COORD_W-1:0];
      REG_BOX_Y:   model_cfg.box_y   = value[COORD_W-1:0];
      REG_BOX_W:   model_cfg.box_w   = value[DIM_W-1:0];
      default:     model_cfg.box_h   = value[DIM_W-1:0];
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_window(logic [DIM_W-1:0] fw, logic [DIM_W-1:0] fh,
                            logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
                            logic [DIM_W-1:0] bw, logic [DIM_W-1:0] bh);
    wait_drained();
    apb_write(REG_FRAME_W, 32'(fw));
    apb_write(REG_FRAME_H, 32'(fh));
    apb_write(REG_BOX_X, 32'(bx));
    apb_write(REG_BOX_Y, 32'(by));
    apb_write(REG_BOX_W, 32'(bw));
    apb_write(REG_BOX_H, 32'(bh));
    config_count++;
  endtask

  // Result side: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      res_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: end_x %0d end_y %0d rejected %0d pixel %h",
               res_if.end_x, res_if.end_y, res_if.rejected, res_if.pixel);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (res_if.end_x !== want.end_x) begin
          $error("end_x: expected %0d, got %0d", want.end_x, res_if.end_x);
          fail_count++;
        end
        if (res_if.end_y !== want.end_y) begin
          $error("end_y: expected %0d, got %0d", want.end_y, res_if.end_y);
          fail_count++;
        end
        if (res_if.rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, res_if.rejected);
          fail_count++;
        end
        if (res_if.pixel !== want.pixel) begin
          $error("pixel: expected %h, got %h", want.pixel, res_if.pixel);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Whole-store clear first, so every later read hits a written pixel.
  task automatic test_full_clear();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    set_window(256, 256, 0, 0, 256, 256);
    send_cmd(CMD_CLEAR, 24'h5A5A5A, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 255, 255);
  endtask

  task automatic test_directed_cases();
    set_window(256, 256, 10, 20, 16, 8);
    send_cmd(CMD_ROW_FILL, 24'hFFFFFF, 5, 0, 0);
    send_cmd(CMD_ROW_FILL, 24'h000000, 3, 15, 0);
    send_cmd(CMD_COL_FILL, 24'h123456, 3, 0, 7);
    send_cmd(CMD_ROW_FILL, 24'h777777, 0, 3, 3);
    send_cmd(CMD_ROW_FILL, 24'h111111, 4, 16, 0);
    send_cmd(CMD_COL_FILL, 24'h222222, 4, 0, 8);
    send_cmd(CMD_ROW_FILL, 24'h333333, 4, 255, 255);
    send_cmd(CMD_READ, 0, 0, 10, 20);
    send_cmd(CMD_ROW_FILL, 24'hA5A5A5, 17'd65536, 0, 0);
    send_cmd(CMD_COL_FILL, 24'h5A5A5A, 17'd65536, 0, 0);
    send_cmd(CMD_ROW_FILL, 24'hC0FFEE, 1, 15, 7);
    send_cmd(CMD_COL_FILL, 24'hBEEF00, 2, 15, 7);
    send_cmd(CMD_READ, 0, 0, 25, 27);
    send_cmd(CMD_READ, 0, 0, 0, 0);
    // one-pixel box in the far corner
    set_window(256, 256, 255, 255, 1, 1);
    send_cmd(CMD_ROW_FILL, 24'h0F0F0F, 5, 0, 0);
    send_cmd(CMD_COL_FILL, 24'hF0F0F0, 1, 0, 0);
    send_cmd(CMD_ROW_FILL, 24'h010101, 1, 1, 0);
    send_cmd(CMD_READ, 0, 0, 255, 255);
    // full-size box starting in the corner spills past the store end
    set_window(256, 256, 255, 255, 256, 256);
    send_cmd(CMD_ROW_FILL, 24'h456789, 600, 0, 0);
    send_cmd(CMD_COL_FILL, 24'h987654, 300, 200, 3);
    send_cmd(CMD_READ, 0, 0, 255, 255);
    set_window(1, 1, 0, 0, 256, 256);
    send_cmd(CMD_CLEAR, 24'hABCDEF, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 255, 255);
  endtask

  // Stall the result side while commands keep coming, then pause until all are back.
  task automatic test_long_stall();
    int unsigned k;
    set_window(256, 256, 40, 40, 32, 32);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    for (k = 0; k < 12; k++) begin
      send_cmd(CMD_ROW_FILL, 24'($urandom()), 17'(k + 1), 8'(k), 8'(k));
    end
    wait_drained();
    send_cmd(CMD_READ, 0, 0, 45, 41);
  endtask

  task automatic test_random_phases();
    int unsigned        phase, k, r, bw, bh, fill_area, frame_area;
    logic [COORD_W-1:0] x, y;
    logic [COUNT_W-1:0] count;
    cmd_e               op;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 5)
        0: set_window(256, 256, 0, 0, 256, 256);
        1: set_window(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)), 255, 255,
                      9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)));
        2: set_window(9'($urandom_range(1, 256)), 9'($urandom_range(1, 64)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      9'($urandom_range(1, 32)), 9'($urandom_range(1, 32)));
        3: set_window(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      9'($urandom_range(1, 64)), 9'($urandom_range(1, 16)));
        default: set_window(256, 9'($urandom_range(1, 256)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 9'($urandom_range(1, 256)),
                            9'($urandom_range(1, 256)));
      endcase
      if (phase < 4) begin
        send_gap_pct   = 30;
        recv_stall_pct = 82;
      end else if (phase < 7) begin
        send_gap_pct   = 82;
        recv_stall_pct = 30;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      bw         = 32'(model_cfg.box_w);
      bh         = 32'(model_cfg.box_h);
      fill_area  = bw * bh;
      frame_area = 32'(model_cfg.frame_w) * 32'(model_cfg.frame_h);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 42) op = CMD_ROW_FILL;
        else if (r < 84) op = CMD_COL_FILL;
        else if (r < 96 || frame_area > 4096) op = CMD_READ;
        else op = CMD_CLEAR;
        if (op == CMD_READ && $urandom_range(0, 1) == 1) begin
          // aim at the box so freshly filled pixels get read back
          x = 8'(32'(model_cfg.box_x) + $urandom_range(0, bw - 1));
          y = 8'(32'(model_cfg.box_y) + $urandom_range(0, bh - 1));
        end else if (op == CMD_READ || $urandom_range(0, 3) == 0) begin
          x = 8'($urandom_range(0, 255));
          y = 8'($urandom_range(0, 255));
        end else begin
          x = 8'($urandom_range(0, bw - 1));
          y = 8'($urandom_range(0, bh - 1));
        end
        // long spans only where the box is small enough to keep the run short
        r = $urandom_range(0, 99);
        if (r < 6) count = '0;
        else if (fill_area <= 1024 && r < 12) count = 17'd65536;
        else if (fill_area <= 1024 && r < 30) count = 17'($urandom_range(0, 65535));
        else count = 17'($urandom_range(1, 96));
        send_cmd(op, 24'($urandom()), count, x, y);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cmd_if.valid    = 1'b0;
    cmd_if.cmd      = CMD_READ;
    cmd_if.color    = '0;
    cmd_if.count    = '0;
    cmd_if.x        = '0;
    cmd_if.y        = '0;
    res_if.ready    = 1'b0;
    model_cfg.frame_w = FRAME_W_RST;
    model_cfg.frame_h = FRAME_H_RST;
    model_cfg.box_x   = BOX_X_RST;
    model_cfg.box_y   = BOX_Y_RST;
    model_cfg.box_w   = BOX_W_RST;
    model_cfg.box_h   = BOX_H_RST;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_full_clear();
    test_directed_cases();
    test_long_stall();
    test_random_phases();

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d commands, checked %0d results over %0d register settings,",
             sent_count, checked_count, config_count);
    $display("covering row and column fills with wrap, rejects, clipped spill, reads, clears.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
